// ===== rtl/b64d_pkg.sv =====
// Shared types, constants and the alphabet lookup for the base64 decoder.
package b64d_pkg;

  localparam logic [7:0] PAD_CHAR    = 8'h3D;
  localparam logic [6:0] BAD_SEXTET  = 7'd64;
  localparam logic [1:0] LAST_POS    = 2'd3;
  localparam logic [1:0] FULL_COUNT  = 2'd3;

  // One decoded group waiting for the output side: up to three bytes.
  typedef struct packed {
    logic [23:0] group;  // bytes, most significant first
    logic [1:0]  count;  // bytes to emit, 1 to 3
    logic        err;    // error result: one zero byte with error set
    logic        last;   // final result of the text ends this group
  } b64d_job_t;

  // Map a character to its 6-bit value; BAD_SEXTET outside the alphabet.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] v;
    v = BAD_SEXTET;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = 7'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = 7'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = 7'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      v = 7'd62;
    end else if (c == 8'h2F) begin
      v = 7'd63;
    end
    return v;
  endfunction

endpackage

// ===== rtl/b64d_front.sv =====
// Front end: accepts characters, tracks group state and queues decoded jobs.
module b64d_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          char_code,
  input  logic                end_of_text,
  output logic                push,
  output b64d_pkg::b64d_job_t job,
  input  logic                queue_full
);

  logic [17:0] acc, acc_next;
  logic [1:0]  pos, pos_next;
  logic        prev_pad, prev_pad_next;
  logic        discarding, discarding_next;

  logic        accept;
  logic        is_pad;
  logic [6:0]  sextet;
  logic [5:0]  bits;
  logic [1:0]  drop;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign is_pad   = (char_code == b64d_pkg::PAD_CHAR);
  assign sextet   = b64d_pkg::sextet_of(char_code);
  assign bits     = is_pad ? 6'd0 : sextet[5:0];
  assign drop     = end_of_text ? (2'(is_pad) + 2'(prev_pad)) : 2'd0;

  // Classify the character and build the job for the back end
  always_comb begin
    acc_next        = acc;
    pos_next        = pos;
    prev_pad_next   = prev_pad;
    discarding_next = discarding;
    push            = 1'b0;
    job             = '0;
    if (accept) begin
      if (discarding) begin
        if (end_of_text) begin
          acc_next        = '0;
          pos_next        = '0;
          prev_pad_next   = 1'b0;
          discarding_next = 1'b0;
        end
      end else if (sextet == b64d_pkg::BAD_SEXTET && !is_pad) begin
        push      = 1'b1;
        job.count = 2'd1;
        job.err   = 1'b1;
        job.last  = end_of_text;
        if (end_of_text) begin
          acc_next      = '0;
          pos_next      = '0;
          prev_pad_next = 1'b0;
        end else begin
          discarding_next = 1'b1;
        end
      end else if (pos != b64d_pkg::LAST_POS) begin
        if (end_of_text) begin
          // text length not a multiple of four
          push          = 1'b1;
          job.count     = 2'd1;
          job.err       = 1'b1;
          job.last      = 1'b1;
          acc_next      = '0;
          pos_next      = '0;
          prev_pad_next = 1'b0;
        end else begin
          acc_next      = {acc[11:0], bits};
          pos_next      = pos + 2'd1;
          prev_pad_next = is_pad;
        end
      end else begin
        push      = 1'b1;
        job.group = {acc, bits};
        job.count = b64d_pkg::FULL_COUNT - drop;
        job.last  = end_of_text;
        acc_next  = '0;
        pos_next  = '0;
        prev_pad_next = end_of_text ? 1'b0 : is_pad;
      end
    end
  end

  // Hold group state
  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      pos        <= '0;
      prev_pad   <= 1'b0;
      discarding <= 1'b0;
    end else begin
      acc        <= acc_next;
      pos        <= pos_next;
      prev_pad   <= prev_pad_next;
      discarding <= discarding_next;
    end
  end

endmodule

// ===== rtl/b64d_queue.sv =====
// Short job queue between the front end and the byte emitter.
module b64d_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  b64d_pkg::b64d_job_t push_job,
  output logic                full,
  input  logic                pop,
  output logic                avail,
  output b64d_pkg::b64d_job_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_MAX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);

  b64d_pkg::b64d_job_t slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] fill;
  logic          do_push, do_pop;

  assign full    = (fill == CNT_MAX);
  assign avail   = (fill != '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && avail;

  // Store incoming job
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_MAX) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_MAX) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

// ===== rtl/b64d_back.sv =====
// Back end: splits each job into bytes and drives the registered output.
module b64d_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                avail,
  input  b64d_pkg::b64d_job_t head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          data_byte,
  output logic                error,
  output logic                last
);

  b64d_pkg::b64d_job_t cur;
  logic       busy;
  logic [1:0] idx;
  logic       out_load;
  logic       final_byte;
  logic [7:0] sel_byte;

  assign out_load   = busy && (!out_valid || out_ready);
  assign final_byte = (idx == cur.count - 2'd1);
  assign pop        = avail && (!busy || (out_load && final_byte));

  // Pick the byte, most significant first
  always_comb begin
    unique case (idx)
      2'd0:    sel_byte = cur.group[23:16];
      2'd1:    sel_byte = cur.group[15:8];
      default: sel_byte = cur.group[7:0];
    endcase
  end

  // Advance through the current job
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (out_load) begin
        if (final_byte) begin
          busy <= 1'b0;
        end else begin
          idx <= idx + 2'd1;
        end
      end
    end
  end

  // Load the next job
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  // Hold the output item until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      data_byte <= sel_byte;
      error     <= cur.err;
      last      <= cur.last && final_byte;
    end
  end

endmodule

// ===== rtl/base64_decoder_core.sv =====
// Top level of the streaming base64 decoder.
//
//  channel  | dir | tdata          | tuser  | tlast
//  s_axis   | in  | [7:0] char     | -      | end_of_text
//  m_axis   | out | [7:0] byte     | error  | last
//
// One character is accepted per cycle while the job queue has room.
// Each complete group yields up to three output items, one per cycle
// while m_tready is high; the byte emitter's pace sets the rate.
// A group's job passes a queue slot and cur before the output register.
// rst is synchronous and clears group state, queue and output valid.
// Output stalls back up through the queue to s_tready.
module base64_decoder_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] char_code
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] data_byte
  output logic       m_tuser,   // [0] error
  output logic       m_tlast
);

  b64d_pkg::b64d_job_t push_job, head;
  logic push, full, pop, avail;

  b64d_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .char_code   (s_tdata),
    .end_of_text (s_tlast),
    .push        (push),
    .job         (push_job),
    .queue_full  (full)
  );

  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .avail    (avail),
    .head     (head)
  );

  b64d_back u_back (
    .clk       (clk),
    .rst       (rst),
    .avail     (avail),
    .head      (head),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .data_byte (m_tdata),
    .error     (m_tuser),
    .last      (m_tlast)
  );

endmodule

// ===== tb/tb_base64_decoder_core.sv =====
// Self-checking testbench for base64_decoder_core: directed table, then random texts.
module tb_base64_decoder_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TARGET_CHARS   = 330;
  localparam int QUIET_FROM     = 290;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int NUM_DIRECTED   = 25;

  // One output item as the block emits it
  typedef struct packed {
    logic [7:0] data;
    logic       err;
    logic       last;
  } b64_result_t;

  // One row of the directed table; res is used only when fixed is set
  typedef struct packed {
    logic [7:0]  c;
    logic        eot;
    logic        fixed;
    b64_result_t res;
  } dir_row_t;

  localparam b64_result_t NO_RES  = '0;
  localparam b64_result_t ERR_MID = '{8'h00, 1'b1, 1'b0};
  localparam b64_result_t ERR_END = '{8'h00, 1'b1, 1'b1};

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = '0;   // [7:0] char_code
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b1;
  logic [7:0] m_tdata;        // [7:0] data_byte
  logic       m_tuser;        // [0] error
  logic       m_tlast;

  // Travel with each item so the monitor sees them at the same edge
  logic        row_fixed = 1'b0;
  b64_result_t row_res = '0;
  logic        ready_hold = 1'b1;

  // Decoder state mirror
  logic [17:0] acc;
  logic [1:0]  pos;
  logic        prev_pad;
  logic        discard;

  b64_result_t decoded_q[$];
  b64_result_t step_out[$];
  logic [7:0]  text_q[$];
  dir_row_t    directed_rows [NUM_DIRECTED];

  int fails = 0;
  int chars_sent = 0;
  int texts_sent = 0;
  int items_checked = 0;
  int error_items = 0;
  int idle_cycles = 0;
  int idle_rate = 2;
  int stall_left = 0;

  base64_decoder_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #1 clk = ~clk;

  // Character to 6-bit value, BAD_SEXTET outside the alphabet
  function automatic logic [6:0] alphabet_index(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) return 7'(c - 8'h41);
    if (c >= 8'h61 && c <= 8'h7A) return 7'(c - 8'h47);
    if (c >= 8'h30 && c <= 8'h39) return 7'(c + 8'h04);
    if (c == 8'h2B) return 7'd62;
    if (c == 8'h2F) return 7'd63;
    return b64d_pkg::BAD_SEXTET;
  endfunction

  // 6-bit value to its character
  function automatic logic [7:0] alpha_char(input int idx);
    if (idx < 26) return 8'(8'h41 + idx);
    if (idx < 52) return 8'(8'h61 + idx - 26);
    if (idx < 62) return 8'(8'h30 + idx - 52);
    if (idx == 62) return 8'h2B;
    return 8'h2F;
  endfunction

  task automatic clear_state();
    acc      = '0;
    pos      = '0;
    prev_pad = 1'b0;
    discard  = 1'b0;
  endtask

  // Work out the output items one accepted character causes
  task automatic decode_char(input logic [7:0] c, input logic eot);
    logic [6:0]  v;
    logic        pad;
    logic [5:0]  sx;
    logic [23:0] grp;
    int          n;
    v   = alphabet_index(c);
    pad = (c == b64d_pkg::PAD_CHAR);
    step_out.delete();
    if (discard) begin
      if (eot) clear_state();
    end else if (v == b64d_pkg::BAD_SEXTET && !pad) begin
      step_out.insert(step_out.size(), b64_result_t'{8'h00, 1'b1, eot});
      if (eot) clear_state();
      else discard = 1'b1;
    end else begin
      sx = pad ? 6'd0 : v[5:0];
      if (pos != b64d_pkg::LAST_POS) begin
        if (eot) begin
          // text ends mid-group: length error
          step_out.insert(step_out.size(), ERR_END);
          clear_state();
        end else begin
          acc      = {acc[11:0], sx};
          pos      = pos + 2'd1;
          prev_pad = pad;
        end
      end else begin
        grp = {acc, sx};
        n   = 3 - (eot ? (int'(pad) + int'(prev_pad)) : 0);
        for (int k = 0; k < n; k++) begin
          step_out.insert(step_out.size(),
                          b64_result_t'{grp[23 - 8 * k -: 8], 1'b0, eot && (k == n - 1)});
        end
        if (eot) begin
          clear_state();
        end else begin
          acc      = '0;
          pos      = '0;
          prev_pad = pad;
        end
      end
    end
  endtask

  // Compare one output item with the oldest expectation
  task automatic check_result();
    b64_result_t exp_r;
    if (decoded_q.size() == 0) begin
      $error("unexpected output item: data_byte %h error %b last %b",
             m_tdata, m_tuser, m_tlast);
      fails++;
    end else begin
      exp_r = decoded_q.pop_front();
      if (m_tdata !== exp_r.data) begin
        $error("data_byte: expected %h, actual %h", exp_r.data, m_tdata);
        fails++;
      end
      if (m_tuser !== exp_r.err) begin
        $error("error: expected %b, actual %b", exp_r.err, m_tuser);
        fails++;
      end
      if (m_tlast !== exp_r.last) begin
        $error("last: expected %b, actual %b", exp_r.last, m_tlast);
        fails++;
      end
    end
    items_checked++;
    if (m_tuser === 1'b1) error_items++;
  endtask

  // Monitor both sides, predict, check, and watch for a hang
  always @(posedge clk) begin
    if (rst) begin
      clear_state();
      idle_cycles = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        decode_char(s_tdata, s_tlast);
        if (row_fixed) decoded_q.insert(decoded_q.size(), row_res);
        else foreach (step_out[i]) decoded_q.insert(decoded_q.size(), step_out[i]);
      end
      if (m_tvalid && m_tready) check_result();
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Stall the output side in random bursts while ready_hold is clear
  always @(posedge clk) begin
    if (rst || ready_hold) begin
      m_tready   <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Offer one character and hold it until accepted
  task automatic send_char(input logic [7:0] c, input logic eot, input logic fix,
                           input b64_result_t res);
    if (idle_rate != 0 && $urandom_range(0, 7) < idle_rate) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid  <= 1'b1;
    s_tdata   <= c;
    s_tlast   <= eot;
    row_fixed <= fix;
    row_res   <= res;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    chars_sent++;
  endtask

  // Build one random text: mostly well-formed, some broken, some noise
  task automatic build_text();
    int         kind;
    int         len;
    int         groups;
    int         npad;
    logic [7:0] b;
    text_q.delete();
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
      end
    end else if (kind == 8) begin
      do len = $urandom_range(1, 11); while (len % 4 == 0);
      for (int i = 0; i < len; i++) begin
        text_q.insert(text_q.size(),
                      ($urandom_range(0, 7) == 0) ? b64d_pkg::PAD_CHAR
                                                  : alpha_char($urandom_range(0, 63)));
      end
    end else begin
      groups = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
      len    = groups * 4;
      for (int i = 0; i < len; i++) begin
        text_q.insert(text_q.size(), alpha_char($urandom_range(0, 63)));
      end
      npad = $urandom_range(0, 2);
      for (int i = 0; i < npad; i++) text_q[len - 1 - i] = b64d_pkg::PAD_CHAR;
      if ($urandom_range(0, 5) == 0) text_q[$urandom_range(0, len - 1)] = b64d_pkg::PAD_CHAR;
      if (kind == 7) begin
        do b = 8'($urandom_range(0, 255));
        while (alphabet_index(b) != b64d_pkg::BAD_SEXTET || b == b64d_pkg::PAD_CHAR);
        text_q[$urandom_range(0, len - 1)] = b;
      end
    end
  endtask

  initial begin
    directed_rows = '{
      '{8'h21, 1'b0, 1'b1, ERR_MID},  // outside the alphabet: error, then skip
      '{"A",   1'b0, 1'b0, NO_RES},   // skipped
      '{"B",   1'b1, 1'b0, NO_RES},   // final char ends the skip silently
      '{"A",   1'b1, 1'b1, ERR_END},  // one-char text: bad length
      '{"/",   1'b0, 1'b0, NO_RES},   // all-ones group
      '{"/",   1'b0, 1'b0, NO_RES},
      '{"/",   1'b0, 1'b0, NO_RES},
      '{"/",   1'b1, 1'b0, NO_RES},
      '{"A",   1'b0, 1'b0, NO_RES},   // all-zeros group, text goes on
      '{"A",   1'b0, 1'b0, NO_RES},
      '{"A",   1'b0, 1'b0, NO_RES},
      '{"A",   1'b0, 1'b0, NO_RES},
      '{"Q",   1'b0, 1'b0, NO_RES},   // two pads: one byte
      '{"Q",   1'b0, 1'b0, NO_RES},
      '{8'h3D, 1'b0, 1'b0, NO_RES},
      '{8'h3D, 1'b1, 1'b0, NO_RES},
      '{"a",   1'b0, 1'b0, NO_RES},   // one pad: two bytes
      '{"+",   1'b0, 1'b0, NO_RES},
      '{"9",   1'b0, 1'b0, NO_RES},
      '{8'h3D, 1'b1, 1'b0, NO_RES},
      '{8'h00, 1'b1, 1'b1, ERR_END},  // lowest byte, final: error with last
      '{"z",   1'b0, 1'b0, NO_RES},   // pad ends a short text: bad length
      '{8'h3D, 1'b1, 1'b1, ERR_END},
      '{8'hFF, 1'b0, 1'b1, ERR_MID},  // highest byte: error, then skip
      '{"A",   1'b1, 1'b0, NO_RES}
    };

    repeat (8) @(posedge clk);
    rst        <= 1'b0;
    ready_hold <= 1'b0;

    // Directed table
    foreach (directed_rows[i]) begin
      send_char(directed_rows[i].c, directed_rows[i].eot,
                directed_rows[i].fixed, directed_rows[i].res);
    end
    texts_sent = 8;

    // Random texts, quiet handshakes near the end
    while (chars_sent < TARGET_CHARS) begin
      build_text();
      if (chars_sent >= QUIET_FROM) begin
        idle_rate = 0;
        ready_hold <= 1'b1;
      end else begin
        idle_rate = $urandom_range(0, 3);
        ready_hold <= ($urandom_range(0, 3) == 0);
      end
      foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1, 1'b0, NO_RES);
      texts_sent++;
    end
    s_tvalid  <= 1'b0;
    row_fixed <= 1'b0;

    // Drain, then allow for stray items
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d characters in %0d texts (pads, bad chars, bad lengths)",
             chars_sent, texts_sent);
    $display("checked %0d output items, %0d of them error items", items_checked,
             error_items);
    if (fails == 0 && decoded_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== base64_decoder_core.f =====
rtl/b64d_pkg.sv
rtl/b64d_front.sv
rtl/b64d_queue.sv
rtl/b64d_back.sv
rtl/base64_decoder_core.sv
tb/tb_base64_decoder_core.sv
